// ===== rtl/lzw_pkg.sv =====
package lzw_pkg;

  localparam int CODE_BITS_DEF = 15;
  localparam int FIRST_CODE    = 256;
  localparam int HASH_BITS     = 13;
  localparam int HASH_DEPTH    = 1 << HASH_BITS;
  localparam logic [31:0] HASH_MULT = 32'd2654435761;
  localparam logic [7:0]  LONG_FLAG = 8'h80;
  localparam logic [7:0]  LOW_MASK  = 8'h7F;

  // bits of the code stream buffer and its fill count
  localparam int ACC_W = 24;
  localparam int CNT_W = 5;

endpackage

// ===== rtl/lzw_ram.sv =====
module lzw_ram import lzw_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/lzw_byte_compressor.sv =====
// channel  | dir | tdata          | tlast        | tuser
// s_axis   | in  | data_byte[7:0] | last_byte    | -
// m_axis   | out | out_byte[7:0]  | stream_done  | item_done
//
// a byte passes through idle, hash, head read and head wait, then one chain step
// per hash chain entry visited; a stream's first byte is taken in idle alone. Sending
// codes adds one emit step per full beat, one to load the second code at a stream
// end and one to finish, which also carries a partial beat. After reset and each stream end
// the hash head ram is cleared, all 8192 buckets, one bucket a cycle, with no byte taken;
// a stalled beat in the output register holds the packer and with it the next byte
module lzw_byte_compressor import lzw_pkg::*; #(
  parameter int CODE_BITS = CODE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // data_byte[7:0]
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_byte[7:0]
  output logic       m_axis_tlast,
  output logic       m_axis_tuser    // item_done
);

  localparam int NUM_CODES = 1 << CODE_BITS;
  localparam int DICT_DEPTH = NUM_CODES - FIRST_CODE;
  localparam int DAW = $clog2(DICT_DEPTH);
  localparam int KEY_W = CODE_BITS + 8;
  localparam int ENT_W = KEY_W + CODE_BITS;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_HASH, ST_HEADRD, ST_HEADWT, ST_CHAIN, ST_EMIT
  } state_e;

  state_e state_q;
  logic [HASH_BITS-1:0] clr_q;
  logic [CODE_BITS:0]   nf_q;
  logic [CODE_BITS-1:0] match_q, recent_q, cur_q;
  logic                 mv_q, rv_q;
  logic [ACC_W-1:0]     acc_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [7:0]           byte_q;
  logic                 last_q, put2_q, flush_q;
  logic [KEY_W-1:0]     key_q;
  logic [HASH_BITS-1:0] hash_q;
  logic [CODE_BITS-1:0] head_q;
  logic                 ovalid_q, odone_q, olast_q;
  logic [7:0]           obyte_q;

  // memories
  logic                 head_we;
  logic [HASH_BITS-1:0] head_waddr, head_raddr;
  logic [CODE_BITS-1:0] head_wdata, head_rdata;
  logic                 ent_we;
  logic [DAW-1:0]       ent_waddr, ent_raddr;
  logic [ENT_W-1:0]     ent_wdata, ent_rdata;

  lzw_ram #(.WIDTH(CODE_BITS), .DEPTH(HASH_DEPTH)) u_head (
    .clk_i, .we_i(head_we), .waddr_i(head_waddr), .wdata_i(head_wdata),
    .raddr_i(head_raddr), .rdata_o(head_rdata)
  );

  lzw_ram #(.WIDTH(ENT_W), .DEPTH(DICT_DEPTH)) u_dict (
    .clk_i, .we_i(ent_we), .waddr_i(ent_waddr), .wdata_i(ent_wdata),
    .raddr_i(ent_raddr), .rdata_o(ent_rdata)
  );

  logic [CODE_BITS-1:0] ent_next;
  logic [KEY_W-1:0]     ent_key;
  assign ent_key  = ent_rdata[KEY_W-1:0];
  assign ent_next = ent_rdata[ENT_W-1:KEY_W];

  // candidate code for the next chain step: fresh head or chain link
  logic [CODE_BITS-1:0] cand;
  logic                 cand_ok;
  logic [CODE_BITS:0]   cand_off;
  assign cand     = (state_q == ST_HEADWT) ? head_rdata : ent_next;
  assign cand_ok  = ({1'b0, cand} >= (CODE_BITS+1)'(FIRST_CODE)) && ({1'b0, cand} < nf_q);
  assign cand_off = {1'b0, cand} - (CODE_BITS+1)'(FIRST_CODE);
  assign ent_raddr = cand_off[DAW-1:0];
  assign head_raddr = hash_q;

  logic [31:0] prod;
  assign prod = 32'(key_q) * HASH_MULT;

  // code as packed bits: short form or flagged low part then high part
  function automatic logic [15:0] code_bits(input logic [CODE_BITS-1:0] c);
    logic [15:0] w;
    w = 16'(c);
    if (w < 16'(LONG_FLAG)) code_bits = w;
    else code_bits = {w[15:7], 7'b0} << 1 | 16'(LONG_FLAG) | (w & 16'(LOW_MASK));
  endfunction

  function automatic logic [CNT_W-1:0] code_len(input logic [CODE_BITS-1:0] c);
    if (16'(c) < 16'(LONG_FLAG)) code_len = CNT_W'(8);
    else code_len = CNT_W'(CODE_BITS + 1);
  endfunction

  logic [ACC_W-1:0] put_acc;
  logic [CNT_W-1:0] put_cnt;
  logic [CODE_BITS-1:0] put_code;
  always_comb begin
    put_code = match_q;
    if (state_q == ST_CHAIN || state_q == ST_HEADWT) put_code = match_q;
    put_acc = acc_q | (ACC_W'(code_bits(put_code)) << cnt_q);
    put_cnt = cnt_q + code_len(put_code);
  end

  logic out_free;
  assign out_free = !ovalid_q || m_axis_tready;

  logic [CNT_W-1:0] rem;
  assign rem = cnt_q - CNT_W'(8);

  logic dict_room;
  assign dict_room = nf_q < (CODE_BITS+1)'(NUM_CODES);

  // add of (match, byte) happens on a miss while the dictionary has room
  logic do_miss, do_hit;
  always_comb begin
    do_miss = 1'b0;
    do_hit  = 1'b0;
    if (state_q == ST_HEADWT && !cand_ok) do_miss = 1'b1;
    if (state_q == ST_CHAIN) begin
      if (ent_key == key_q) begin
        if (rv_q && cur_q == recent_q) do_miss = 1'b1;
        else do_hit = 1'b1;
      end else if (!cand_ok) begin
        do_miss = 1'b1;
      end
    end
  end

  logic [CODE_BITS:0] nf_off;
  assign nf_off = nf_q - (CODE_BITS+1)'(FIRST_CODE);

  always_comb begin
    head_we    = 1'b0;
    head_waddr = hash_q;
    head_wdata = nf_q[CODE_BITS-1:0];
    ent_we     = do_miss && dict_room;
    ent_waddr  = nf_off[DAW-1:0];
    // new entry links to the bucket head read for this byte
    ent_wdata  = {(state_q == ST_HEADWT) ? head_rdata : head_q, key_q};
    if (state_q == ST_CLEAR) begin
      head_we    = 1'b1;
      head_waddr = clr_q;
      head_wdata = '0;
    end else if (do_miss && dict_room) begin
      head_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      nf_q     <= (CODE_BITS+1)'(FIRST_CODE);
      match_q  <= '0;
      mv_q     <= 1'b0;
      recent_q <= '0;
      rv_q     <= 1'b0;
      acc_q    <= '0;
      cnt_q    <= '0;
      put2_q   <= 1'b0;
      flush_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (&clr_q) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            byte_q  <= s_axis_tdata;
            last_q  <= s_axis_tlast;
            key_q   <= {match_q, s_axis_tdata};
            flush_q <= s_axis_tlast;
            put2_q  <= 1'b0;
            if (!mv_q) begin
              match_q <= CODE_BITS'(s_axis_tdata);
              mv_q    <= 1'b1;
              if (s_axis_tlast) begin
                acc_q   <= acc_q | (ACC_W'(code_bits(CODE_BITS'(s_axis_tdata))) << cnt_q);
                cnt_q   <= cnt_q + code_len(CODE_BITS'(s_axis_tdata));
                state_q <= ST_EMIT;
              end
            end else begin
              state_q <= ST_HASH;
            end
          end
        end
        ST_HASH: begin
          hash_q  <= prod[31 -: HASH_BITS];
          state_q <= ST_HEADRD;
        end
        ST_HEADRD: state_q <= ST_HEADWT;
        ST_HEADWT, ST_CHAIN: begin
          if (state_q == ST_HEADWT) head_q <= head_rdata;
          cur_q <= cand;
          if (do_hit) begin
            match_q <= cur_q;
            if (last_q) begin
              acc_q   <= acc_q | (ACC_W'(code_bits(cur_q)) << cnt_q);
              cnt_q   <= cnt_q + code_len(cur_q);
              state_q <= ST_EMIT;
            end else begin
              state_q <= ST_IDLE;
            end
          end else if (do_miss) begin
            acc_q   <= put_acc;
            cnt_q   <= put_cnt;
            match_q <= CODE_BITS'(byte_q);
            put2_q  <= last_q;
            if (dict_room) begin
              recent_q <= nf_q[CODE_BITS-1:0];
              rv_q     <= 1'b1;
              nf_q     <= nf_q + 1'b1;
            end else begin
              rv_q <= 1'b0;
            end
            state_q <= ST_EMIT;
          end else begin
            state_q <= ST_CHAIN;
          end
        end
        ST_EMIT: begin
          if (cnt_q >= CNT_W'(8)) begin
            if (out_free) begin
              ovalid_q <= 1'b1;
              obyte_q  <= acc_q[7:0];
              odone_q  <= (rem < CNT_W'(8)) && !put2_q && !(flush_q && rem != '0);
              olast_q  <= (rem < CNT_W'(8)) && !put2_q && !(flush_q && rem != '0)
                          && flush_q;
              acc_q    <= acc_q >> 8;
              cnt_q    <= rem;
            end
          end else if (put2_q) begin
            acc_q  <= put_acc;
            cnt_q  <= put_cnt;
            put2_q <= 1'b0;
          end else if (flush_q) begin
            if (cnt_q == '0 || out_free) begin
              if (cnt_q != '0) begin
                ovalid_q <= 1'b1;
                obyte_q  <= acc_q[7:0];
                odone_q  <= 1'b1;
                olast_q  <= 1'b1;
              end
              // end of stream: dictionary, match and packer back to reset
              nf_q     <= (CODE_BITS+1)'(FIRST_CODE);
              match_q  <= '0;
              mv_q     <= 1'b0;
              recent_q <= '0;
              rv_q     <= 1'b0;
              acc_q    <= '0;
              cnt_q    <= '0;
              flush_q  <= 1'b0;
              clr_q    <= '0;
              state_q  <= ST_CLEAR;
            end
          end else begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = obyte_q;
  assign m_axis_tuser  = odone_q;
  assign m_axis_tlast  = olast_q;

  a_idle_no_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (!put2_q && !flush_q && cnt_q < CNT_W'(8)))
    else $error("packer busy while taking a byte");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < CNT_W'(ACC_W))
    else $error("bit buffer overflow");
  a_stream_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
    else $error("stream end without item end");
  a_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nf_q <= (CODE_BITS+1)'(NUM_CODES) && nf_q >= (CODE_BITS+1)'(FIRST_CODE))
    else $error("free code out of range");

endmodule

// ===== sim/lzw_byte_compressor_tb.sv =====
`timescale 1ns / 100ps

module lzw_byte_compressor_tb;
  import lzw_pkg::*;

  localparam int CB = CODE_BITS_DEF;
  localparam int NUM_CODES = 1 << CB;

  typedef struct packed {
    logic [7:0] data;
    logic       item_done;
    logic       stream_done;
  } packed_beat_t;

  // tracks dictionary, match and bit packer; holds the packed bytes still due
  class LzwCodeTracker;
    int unsigned   code_of[int unsigned];
    int unsigned   next_code;
    int unsigned   match;
    bit            match_ok;
    int unsigned   recent;
    bit            recent_ok;
    int unsigned   bits;
    int unsigned   nbits;
    packed_beat_t  due_q[$];
    packed_beat_t  step_q[$];
    int            errors;

    function new();
      restart();
      errors = 0;
    endfunction

    function void restart();
      code_of.delete();
      next_code = FIRST_CODE;
      match = 0;
      match_ok = 0;
      recent = 0;
      recent_ok = 0;
      bits = 0;
      nbits = 0;
    endfunction

    function void push_byte(int unsigned v);
      packed_beat_t pb;
      pb.data = v[7:0];
      pb.item_done = 0;
      pb.stream_done = 0;
      step_q = {step_q, pb};
    endfunction

    function void put_bits(int unsigned val, int unsigned n);
      int unsigned acc;
      int unsigned cnt;
      acc = bits | ((val & ((1 << n) - 1)) << nbits);
      cnt = nbits + n;
      while (cnt >= 8) begin
        push_byte(acc & 8'hFF);
        acc = acc >> 8;
        cnt -= 8;
      end
      bits = acc & 8'hFF;
      nbits = cnt;
    endfunction

    function void put_code(int unsigned code);
      if (code < LONG_FLAG) begin
        put_bits(code, 8);
      end else begin
        put_bits((code & LOW_MASK) | LONG_FLAG, 8);
        put_bits(code >> 7, CB - 7);
      end
    endfunction

    // accepted input byte: advance the compressor and queue its packed beats
    function void note_byte(logic [7:0] b, logic last);
      int unsigned key;
      int unsigned child;
      key = ((match & 15'h7FFF) << 8) | b;
      step_q.delete();
      if (match_ok) begin
        child = code_of.exists(key) ? code_of[key] : 0;
        if (child != 0 && !(recent_ok && child == recent)) begin
          match = child;
        end else begin
          put_code(match);
          if (next_code < NUM_CODES) begin
            code_of[key] = next_code;   // newest code wins for a repeated pair
            recent = next_code;
            recent_ok = 1;
            next_code++;
          end else begin
            recent_ok = 0;
          end
          match = b;
        end
      end else begin
        match = b;
        match_ok = 1;
      end
      if (last) begin
        put_code(match);
        if (nbits > 0) push_byte(bits);
        restart();
      end
      if (step_q.size() > 0) begin
        step_q[step_q.size()-1].item_done = 1;
        step_q[step_q.size()-1].stream_done = last;
      end
      due_q = {due_q, step_q};
    endfunction

    function void check_beat(logic [7:0] d, logic sdone, logic idone);
      packed_beat_t exp_b;
      if (due_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat data=%h tlast=%b tuser=%b", d, sdone, idone);
        return;
      end
      exp_b = due_q.pop_front();
      if (exp_b.data !== d || exp_b.stream_done !== sdone || exp_b.item_done !== idone) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp data=%h tlast=%b tuser=%b got data=%h tlast=%b tuser=%b",
                   exp_b.data, exp_b.stream_done, exp_b.item_done, d, sdone, idone);
      end
    endfunction
  endclass

  logic       clk_i = 0;
  logic       rst_ni = 0;
  logic       s_axis_tvalid = 0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 0;
  logic       s_axis_tlast = 0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic       m_axis_tuser;

  LzwCodeTracker tracker = new();
  bit burst_mode = 0;   // no idling on either side while set

  always #5 clk_i = ~clk_i;

  lzw_byte_compressor u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser
  );

  function automatic int unsigned draw_gap();
    if (burst_mode || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  task automatic send_byte(logic [7:0] d, logic last);
    int unsigned gap;
    gap = draw_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= d;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_byte(d, last);
  endtask

  // packed beat sink with random stalls
  initial begin
    int unsigned stall;
    wait (rst_ni);
    forever begin
      stall = draw_gap();
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      tracker.check_beat(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end
  end

  initial begin
    int unsigned len;
    int unsigned n_items;
    int unsigned alpha;
    logic [7:0] b;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // single byte streams at both ends of the byte range
    send_byte(8'h00, 1);
    send_byte(8'hFF, 1);
    // run of one byte: the pair repeats right after being added
    repeat (7) send_byte(8'h61, 0);
    send_byte(8'h61, 1);
    // codes around the long form boundary
    send_byte(8'h7F, 0);
    send_byte(8'h80, 0);
    send_byte(8'h7F, 0);
    send_byte(8'h80, 0);
    send_byte(8'h7F, 0);
    send_byte(8'h80, 0);
    send_byte(8'h7F, 0);
    send_byte(8'h80, 1);

    // random streams, mostly from small alphabets so matches grow long
    n_items = 0;
    while (n_items < 460) begin
      burst_mode = ($urandom_range(0, 4) == 0);
      len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
      alpha = $urandom_range(0, 3);
      for (int i = 0; i < len; i++) begin
        case (alpha)
          0: b = 8'($urandom);
          1: b = 8'h41 + 8'($urandom_range(0, 1));
          2: b = ($urandom_range(0, 1)) ? 8'hFF : 8'h00;
          default: b = 8'hF0 + 8'($urandom_range(0, 3));
        endcase
        send_byte(b, i == len - 1);
        n_items++;
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 0;
    burst_mode = 0;

    while (tracker.due_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.due_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
